[hw/rtl/curve_speed_boost_ramp_unit_defines.svh]
// Assertion macros for the boost ramp unit.
`ifndef CURVE_SPEED_BOOST_RAMP_UNIT_DEFINES_SVH
`define CURVE_SPEED_BOOST_RAMP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CSBR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define CSBR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CSBR_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CSBR_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hw/rtl/csbr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package csbr_pkg;

   typedef struct packed {
      logic [6:0] row_index;
      logic [7:0] mid_column;
      logic       end_of_frame;
      logic       hold_off;
   } csbr_req_type;

   typedef struct packed {
      logic [7:0] boost_out;
      logic [7:0] boost_target;
      logic       line_lost;
   } csbr_rsp_type;

   typedef struct packed {
      logic [7:0] center_col;
      logic [7:0] full_boost;
      logic [7:0] straight_tolerance;
      logic [7:0] curve_threshold;
      logic [7:0] ramp_up_step;
      logic [7:0] ramp_down_step;
      logic [6:0] band_far_row;
      logic [6:0] band_near_row;
   } csbr_cfg_type;

   typedef enum logic [2:0] {
      REG_CENTER_COL         = 3'd0,
      REG_FULL_BOOST         = 3'd1,
      REG_STRAIGHT_TOLERANCE = 3'd2,
      REG_CURVE_THRESHOLD    = 3'd3,
      REG_RAMP_UP_STEP       = 3'd4,
      REG_RAMP_DOWN_STEP     = 3'd5,
      REG_BAND_FAR_ROW       = 3'd6,
      REG_BAND_NEAR_ROW      = 3'd7
   } csbr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TARGET,
      ST_DIV,
      ST_RAMP,
      ST_OUT
   } csbr_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } csbr_div_status_type;

   localparam int DIVIDEND_W = 16;
   localparam int DIVISOR_W  = 8;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam csbr_cfg_type CFG_RESET = '{
      center_col:         8'd94,
      full_boost:         8'd40,
      straight_tolerance: 8'd8,
      curve_threshold:    8'd30,
      ramp_up_step:       8'd1,
      ramp_down_step:     8'd5,
      band_far_row:       7'd25,
      band_near_row:      7'd40
   };

endpackage
`default_nettype wire

[hw/rtl/curve_speed_boost_ramp_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Speed boost ramp from mid-line curvature.
// req channel: one item per image row (row index, mid-line column, end of frame, hold).
//   Rows that do not end a frame are taken one per cycle; req_stall stays low.
// An end-of-frame item raises req_stall while the target and the ramp are worked out:
//   the target checks come first, then a wait on the bit-serial divider
//   (16 steps, then the quotient is handed back) when the deviation lies between
//   tolerance and threshold, then the ramp step, then the load of the result.
//   A hold frame skips the division and the ramp and goes straight to the load;
//   the load waits while the output register is still held by rsp_stall.
// rsp channel: one item per frame, held in an output register. While rsp_stall is
//   high the item stays put and new rows are still taken; the next frame result
//   waits in the sequencer until the register frees.
// csr channel: always ready; write only while no frame result is in flight.
// Reset: synchronous, active high. Registers return to their default values, the
//   boost level and the frame accumulators clear, no rsp item is pending.
module curve_speed_boost_ramp_unit #(
   parameter int IMAGE_WIDTH = 188,
   parameter int IMAGE_ROWS  = 128
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire csbr_pkg::csbr_req_type req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output csbr_pkg::csbr_rsp_type     rsp_item,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [2:0]            csr_index,
   input  wire logic [7:0]            csr_data
);
   import csbr_pkg::*;
`include "curve_speed_boost_ramp_unit_defines.svh"

   localparam logic [7:0] ROW_LIMIT = 8'(IMAGE_ROWS);
   localparam logic [7:0] COL_LIMIT = 8'(IMAGE_WIDTH);

   csbr_state_type       state_ff, state_in;
   csbr_cfg_type         cfg_ff, cfg_in;
   logic [7:0]           boost_ff, boost_in;
   logic [7:0]           max_dev_ff, max_dev_in;
   logic                 any_valid_ff, any_valid_in;
   logic                 hold_ff, hold_in;
   logic [7:0]           target_ff, target_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   csbr_rsp_type         rsp_item_ff, rsp_item_in;

   logic                 req_accept;
   logic                 in_band;
   logic [7:0]           dev;
   logic                 div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   csbr_div_status_type  div_status;
   logic [DIVIDEND_W-1:0] div_quotient;
   logic [8:0]           ramp_sum;
   logic                 out_free;

   csbr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= CFG_RESET;
         boost_ff     <= '0;
         max_dev_ff   <= '0;
         any_valid_ff <= 1'b0;
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         boost_ff     <= boost_in;
         max_dev_ff   <= max_dev_in;
         any_valid_ff <= any_valid_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff   <= target_in;
      rsp_item_ff <= rsp_item_in;
   end

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csbr_reg_type'(csr_index))
            REG_CENTER_COL:         cfg_in.center_col         = csr_data;
            REG_FULL_BOOST:         cfg_in.full_boost         = csr_data;
            REG_STRAIGHT_TOLERANCE: cfg_in.straight_tolerance = csr_data;
            REG_CURVE_THRESHOLD:    cfg_in.curve_threshold    = csr_data;
            REG_RAMP_UP_STEP:       cfg_in.ramp_up_step       = csr_data;
            REG_RAMP_DOWN_STEP:     cfg_in.ramp_down_step     = csr_data;
            REG_BAND_FAR_ROW:       cfg_in.band_far_row       = csr_data[6:0];
            REG_BAND_NEAR_ROW:      cfg_in.band_near_row      = csr_data[6:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      req_accept = req_valid && !req_stall;
      in_band    = ({1'b0, req_item.row_index} < ROW_LIMIT)
                   && (req_item.row_index >= cfg_ff.band_far_row)
                   && (req_item.row_index <= cfg_ff.band_near_row)
                   && (req_item.mid_column < COL_LIMIT);
      dev        = (req_item.mid_column >= cfg_ff.center_col)
                   ? req_item.mid_column - cfg_ff.center_col
                   : cfg_ff.center_col - req_item.mid_column;
      ramp_sum   = {1'b0, boost_ff} + {1'b0, cfg_ff.ramp_up_step};
      out_free   = !rsp_valid_ff || !rsp_stall;

      div_start    = 1'b0;
      div_dividend = {8'd0, cfg_ff.full_boost}
                     * {8'd0, 8'(cfg_ff.curve_threshold - max_dev_ff)};
      div_divisor  = cfg_ff.curve_threshold - cfg_ff.straight_tolerance;

      state_in     = state_ff;
      boost_in     = boost_ff;
      max_dev_in   = max_dev_ff;
      any_valid_in = any_valid_ff;
      hold_in      = hold_ff;
      target_in    = target_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (in_band) begin
                  any_valid_in = 1'b1;
                  if (dev > max_dev_ff) max_dev_in = dev;
               end
               if (req_item.hold_off) boost_in = '0;
               hold_in = req_item.hold_off;
               if (req_item.end_of_frame) state_in = ST_TARGET;
            end
         end
         ST_TARGET: begin
            priority if (hold_ff) begin
               target_in = '0;
               state_in  = ST_OUT;
            end else if (!any_valid_ff) begin
               target_in = '0;
               state_in  = ST_RAMP;
            end else if (max_dev_ff <= cfg_ff.straight_tolerance) begin
               target_in = cfg_ff.full_boost;
               state_in  = ST_RAMP;
            end else if (cfg_ff.curve_threshold <= cfg_ff.straight_tolerance
                         || max_dev_ff >= cfg_ff.curve_threshold) begin
               target_in = '0;
               state_in  = ST_RAMP;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               target_in = (div_quotient > {8'd0, cfg_ff.full_boost})
                           ? cfg_ff.full_boost : div_quotient[7:0];
               state_in  = ST_RAMP;
            end
         end
         ST_RAMP: begin
            priority if (boost_ff < target_ff) begin
               boost_in = (ramp_sum > {1'b0, target_ff}) ? target_ff : ramp_sum[7:0];
            end else if (boost_ff > target_ff) begin
               boost_in = (boost_ff >= cfg_ff.ramp_down_step)
                          ? boost_ff - cfg_ff.ramp_down_step : 8'd0;
            end else begin
               boost_in = boost_ff;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.boost_out    = boost_ff;
               rsp_item_in.boost_target = target_ff;
               rsp_item_in.line_lost    = !any_valid_ff;
               max_dev_in               = '0;
               any_valid_in             = 1'b0;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign csr_ready = 1'b1;

   `CSBR_ASSERT_IMP(a_div_done_in_div, clock, reset, div_status.done,
      state_ff == ST_DIV, "divider finished outside its wait state")
   `CSBR_ASSERT_IMP(a_idle_div_quiet, clock, reset, state_ff == ST_IDLE,
      !div_status.busy, "divider busy while idle")
   `CSBR_ASSERT_NXT(a_eof_starts_update, clock, reset, req_accept && req_item.end_of_frame,
      state_ff == ST_TARGET, "frame end did not start the update")
   `CSBR_ASSERT_NXT(a_out_clears_frame, clock, reset, state_ff == ST_OUT && out_free,
      rsp_valid_ff && max_dev_ff == 8'd0 && !any_valid_ff,
      "frame result not loaded or accumulators not cleared")

endmodule
`default_nettype wire

[hw/rtl/csbr_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
module csbr_divider (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   input  wire logic [csbr_pkg::DIVIDEND_W-1:0]         dividend,
   input  wire logic [csbr_pkg::DIVISOR_W-1:0]          divisor,
   output csbr_pkg::csbr_div_status_type                status,
   output logic      [csbr_pkg::DIVIDEND_W-1:0]         quotient
);
   import csbr_pkg::*;

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   always_comb begin
      trial      = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial_diff = trial - {1'b0, dvs_ff};
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dvs_in     = dvs_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial_diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule
`default_nettype wire
